[sv/ape_pkg.sv]
// Shared types, constants and fixed-point helpers for the axis projection extent block.
`default_nettype none
package ape_pkg;

  // Coordinate format
  localparam int CW        = 32;
  localparam int FRAC_BITS = 16;
  localparam int WIDE      = 2 * CW + 2;

  // Stream widths, rounded up to whole bytes
  localparam int IN_W  = ((3 * CW + 7) / 8) * 8;
  localparam int OUT_W = ((7 * CW + 7) / 8) * 8;

  // Config port
  localparam int CFG_IDX_W = 3;

  // Queue between projection pipeline and extent tracker
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef logic signed [CW-1:0]   coord_t;
  typedef logic        [CW-1:0]   ucoord_t;
  typedef logic signed [CW:0]     ext_t;
  typedef logic signed [WIDE-1:0] wide_t;

  localparam coord_t  CMAX  = {1'b0, {(CW - 1){1'b1}}};
  localparam coord_t  CMIN  = {1'b1, {(CW - 1){1'b0}}};
  localparam coord_t  ONE_Q = coord_t'(1 << FRAC_BITS);
  localparam ucoord_t UONE  = ucoord_t'(1 << FRAC_BITS);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AXIS_POINT_X = 3'd0,
    REG_AXIS_POINT_Y = 3'd1,
    REG_AXIS_POINT_Z = 3'd2,
    REG_AXIS_DIR_X   = 3'd3,
    REG_AXIS_DIR_Y   = 3'd4,
    REG_AXIS_DIR_Z   = 3'd5,
    REG_INVERSE_NORM = 3'd6
  } reg_idx_t;

  typedef struct packed {
    coord_t  ap_x;
    coord_t  ap_y;
    coord_t  ap_z;
    coord_t  dir_x;
    coord_t  dir_y;
    coord_t  dir_z;
    ucoord_t inv_norm;
  } cfg_t;

  // One projection waiting for the extent tracker
  typedef struct packed {
    coord_t t;
    logic   last;
  } item_t;

  typedef struct packed {
    coord_t height;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
  } result_t;

  // Clamp a wide signed value to the coordinate range
  function automatic coord_t sat_w(input wide_t v);
    coord_t r;
    if (v > wide_t'(CMAX)) begin
      r = CMAX;
    end else if (v < wide_t'(CMIN)) begin
      r = CMIN;
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

  // Fixed-point multiply: exact product, floor shift, clamp
  function automatic coord_t mul_q(input ext_t a, input ext_t b);
    wide_t p;
    p = wide_t'(a) * wide_t'(b);
    return sat_w(p >>> FRAC_BITS);
  endfunction

endpackage
`default_nettype wire

[sv/ape_front.sv]
// Projection pipeline: offset, dot product with the axis, scale by inverse norm.
`default_nettype none
module ape_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ape_pkg::cfg_t        cfg,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [ape_pkg::IN_W-1:0] s_tdata,
  input  wire logic                 s_tlast,
  input  wire logic                 q_full,
  output logic                      q_push,
  output ape_pkg::item_t            q_item
);
  import ape_pkg::*;

  logic   v0, v1, v2, v3;
  logic   l0, l1, l2, l3;
  coord_t d_x, d_y, d_z;
  coord_t dx, dy, dz;
  coord_t px, py, pz;
  coord_t dot;
  coord_t t;
  logic   stall;

  // Whole pipeline holds while the last stage cannot drain
  assign stall    = v3 && q_full;
  assign s_tready = !stall;
  assign q_push   = v3 && !q_full;
  assign q_item   = '{t: t, last: l3};

  // Offset from the axis point
  always_comb begin
    d_x = sat_w(wide_t'(coord_t'(s_tdata[CW-1:0]))      - wide_t'(cfg.ap_x));
    d_y = sat_w(wide_t'(coord_t'(s_tdata[2*CW-1:CW]))   - wide_t'(cfg.ap_y));
    d_z = sat_w(wide_t'(coord_t'(s_tdata[3*CW-1:2*CW])) - wide_t'(cfg.ap_z));
  end

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (!stall) begin
      v0 <= s_tvalid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Stage data
  always_ff @(posedge clk) begin
    if (!stall) begin
      dx  <= d_x;
      dy  <= d_y;
      dz  <= d_z;
      l0  <= s_tlast;
      px  <= mul_q(ext_t'(dx), ext_t'(cfg.dir_x));
      py  <= mul_q(ext_t'(dy), ext_t'(cfg.dir_y));
      pz  <= mul_q(ext_t'(dz), ext_t'(cfg.dir_z));
      l1  <= l0;
      dot <= sat_w(wide_t'(px) + wide_t'(py) + wide_t'(pz));
      l2  <= l1;
      t   <= mul_q(ext_t'(dot), ext_t'({1'b0, cfg.inv_norm}));
      l3  <= l2;
    end
  end

endmodule
`default_nettype wire

[sv/ape_queue.sv]
// Small FIFO of projections between the pipeline and the extent tracker.
`default_nettype none
module ape_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire ape_pkg::item_t push_item,
  output logic                full,
  input  wire logic           pop,
  output ape_pkg::item_t      head,
  output logic                empty
);
  import ape_pkg::*;

  item_t                 mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [QUEUE_AW:0]     count;

  assign full  = (count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule
`default_nettype wire

[sv/ape_back.sv]
// Extent tracker: running min/max of projections and the result sequencer.
`default_nettype none
module ape_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire ape_pkg::cfg_t  cfg,
  input  wire ape_pkg::item_t head,
  input  wire logic           q_empty,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output ape_pkg::result_t    result
);
  import ape_pkg::*;

  typedef enum logic {ST_IDLE, ST_CALC} state_t;

  state_t       state;
  logic         have_point;
  coord_t       min_t, max_t;
  coord_t       res_min, res_max;
  coord_t       new_min, new_max;
  coord_t       height;
  coord_t       res_pt [6];
  coord_t       prod;
  logic [2:0]   cnt;
  logic [2:0]   widx;
  logic [1:0]   paxis;
  logic [1:0]   axis_sel;
  coord_t       t_sel, dir_sel, base_sel;

  // Last item waits until the previous result has been taken
  assign q_pop = (state == ST_IDLE) && !q_empty && (!head.last || !out_valid);

  // Candidate extremes with the head item folded in
  always_comb begin
    new_min = (!have_point || head.t < min_t) ? head.t : min_t;
    new_max = (!have_point || head.t > max_t) ? head.t : max_t;
  end

  // Operand selection for the shared multiplier and the adder behind it
  always_comb begin
    axis_sel = (cnt < 3'd3) ? cnt[1:0] : 2'(cnt - 3'd3);
    t_sel    = (cnt < 3'd3) ? res_max : res_min;
    unique case (axis_sel)
      2'd0:    dir_sel = cfg.dir_x;
      2'd1:    dir_sel = cfg.dir_y;
      default: dir_sel = cfg.dir_z;
    endcase
    unique case (paxis)
      2'd0:    base_sel = cfg.ap_x;
      2'd1:    base_sel = cfg.ap_y;
      default: base_sel = cfg.ap_z;
    endcase
  end

  assign result = '{height: height,
                    max_x: res_pt[0], max_y: res_pt[1], max_z: res_pt[2],
                    min_x: res_pt[3], min_y: res_pt[4], min_z: res_pt[5]};

  // State, extent registers and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      have_point <= 1'b0;
      min_t      <= '0;
      max_t      <= '0;
      cnt        <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_pop) begin
            if (head.last) begin
              res_min    <= new_min;
              res_max    <= new_max;
              min_t      <= '0;
              max_t      <= '0;
              have_point <= 1'b0;
              cnt        <= '0;
              state      <= ST_CALC;
            end else begin
              min_t      <= new_min;
              max_t      <= new_max;
              have_point <= 1'b1;
            end
          end
        end
        ST_CALC: begin
          // Multiply for step cnt, add for the step before it
          if (cnt < 3'd6) begin
            prod  <= mul_q(ext_t'(t_sel), ext_t'(dir_sel));
            widx  <= cnt;
            paxis <= axis_sel;
          end
          if (cnt == 3'd0) begin
            height <= sat_w(wide_t'(res_max) - wide_t'(res_min));
          end else begin
            res_pt[widx] <= sat_w(wide_t'(base_sel) + wide_t'(prod));
          end
          if (cnt == 3'd6) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[sv/axis_projection_extent.sv]
// Top level of the axis projection extent block: config registers and stream ports.
//
// Points stream in on the slave side and are projected onto a configured axis
// through a four-stage pipeline (offset, three products, sum, inverse-norm
// scale); a four-entry queue then feeds the min/max tracker. Ordinary points
// are taken one per cycle unless a full queue holds the pipeline. A point
// with tlast closes the cloud: the tracker folds the point in, then computes
// the height and runs the six extreme point products through its single
// shared multiplier, and presents one result beat; it only starts on a
// closing point once the previous result beat has been taken, and meanwhile
// input keeps flowing until the queue fills. Configuration is to be written
// through the plain write port while no cloud is in flight (the user's duty, not
// enforced by the block); an index beyond the register list is ignored.
`default_nettype none
module axis_projection_extent (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Config write port
  input  wire logic                          cfg_we,
  input  wire logic [ape_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ape_pkg::CW-1:0]        cfg_data,
  // Point stream
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [ape_pkg::IN_W-1:0]      s_tdata,  // point_x, point_y, point_z
  input  wire logic                          s_tlast,  // last_point
  // Result stream
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // height, max_x, max_y, max_z, min_x, min_y, min_z
  output logic [ape_pkg::OUT_W-1:0]          m_tdata
);
  import ape_pkg::*;

  cfg_t    cfg;
  item_t   q_item;
  item_t   q_head;
  logic    q_push, q_pop, q_full, q_empty;
  result_t result;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ap_x     <= '0;
      cfg.ap_y     <= '0;
      cfg.ap_z     <= '0;
      cfg.dir_x    <= '0;
      cfg.dir_y    <= '0;
      cfg.dir_z    <= ONE_Q;
      cfg.inv_norm <= UONE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_AXIS_POINT_X: cfg.ap_x     <= coord_t'(cfg_data);
        REG_AXIS_POINT_Y: cfg.ap_y     <= coord_t'(cfg_data);
        REG_AXIS_POINT_Z: cfg.ap_z     <= coord_t'(cfg_data);
        REG_AXIS_DIR_X:   cfg.dir_x    <= coord_t'(cfg_data);
        REG_AXIS_DIR_Y:   cfg.dir_y    <= coord_t'(cfg_data);
        REG_AXIS_DIR_Z:   cfg.dir_z    <= coord_t'(cfg_data);
        REG_INVERSE_NORM: cfg.inv_norm <= cfg_data;
        default: ;
      endcase
    end
  end

  ape_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_item)
  );

  ape_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  ape_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .result    (result)
  );

  // Pack result fields, first field in the lowest bits
  assign m_tdata = OUT_W'({result.min_z, result.min_y, result.min_x,
                           result.max_z, result.max_y, result.max_x,
                           result.height});

endmodule
`default_nettype wire

[sv/ape_checker.sv]
// Port-level assertions for the axis projection extent block, bound to the top level.
`default_nettype none
module ape_checker (
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     s_tvalid,
  input wire logic                     s_tready,
  input wire logic                     s_tlast,
  input wire logic                     m_tvalid,
  input wire logic                     m_tready,
  input wire logic [ape_pkg::OUT_W-1:0] m_tdata
);
  import ape_pkg::*;

  logic [3:0] pending;

  // Closing beats taken minus result beats delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      unique case ({s_tvalid && s_tready && s_tlast, m_tvalid && m_tready})
        2'b10:   pending <= pending + 1'b1;
        2'b01:   pending <= pending - 1'b1;
        default: pending <= pending;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result beat changed while stalled");

  a_height_nonneg: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[CW-1])
    else $error("height is negative");

  a_result_owed: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready |-> pending != '0)
    else $error("result beat without a closing point");

endmodule

bind axis_projection_extent ape_checker u_ape_checker (.*);
`default_nettype wire
